// ===== rtl/wvm_pkg.sv =====
// Shared types, constants and multiply helpers for the variance merge block.
package wvm_pkg;

   // widths fixed by the register and field formats
   localparam int WeightW    = 40;
   localparam int CountW     = 32;
   localparam int CrossFrac  = 24;
   localparam int FracBitsDefault = 32;

   // configuration register indexes
   typedef enum logic [2:0] {
      CSR_WEIGHT_A    = 3'd0,
      CSR_WEIGHT_B    = 3'd1,
      CSR_COUNT_A     = 3'd2,
      CSR_COUNT_B     = 3'd3,
      CSR_VARIANCE_ON = 3'd4
   } csr_index_type;

   // derivation sequencer states
   typedef enum logic [2:0] {
      DV_IDLE,
      DV_LOAD_A,
      DV_DIV_A,
      DV_LOAD_B,
      DV_DIV_B,
      DV_MULT,
      DV_LOAD_C,
      DV_DIV_C
   } dv_state_type;

   // four 32x32 partial products of a 64x64 multiply
   typedef logic [3:0][63:0] pp_type;

   // per-bin values that ride alongside the cross term
   typedef struct packed {
      logic [63:0] sum_a;
      logic [63:0] sum_sat;
      logic        sum_ovf;
      logic [62:0] m2_a;
      logic [62:0] m2_b;
      logic        last;
   } side_type;

   function automatic pp_type pp_mul(input logic [63:0] a, input logic [63:0] b);
      pp_type p;
      p[0] = 64'(a[31:0]) * 64'(b[31:0]);
      p[1] = 64'(a[31:0]) * 64'(b[63:32]);
      p[2] = 64'(a[63:32]) * 64'(b[31:0]);
      p[3] = 64'(a[63:32]) * 64'(b[63:32]);
      return p;
   endfunction

   function automatic logic [127:0] pp_sum(input pp_type p);
      return {64'b0, p[0]} + ({64'b0, p[1]} << 32) + ({64'b0, p[2]} << 32) + {p[3], 64'b0};
   endfunction

endpackage

// ===== rtl/welford_variance_merge_top.sv =====
// Top level of the two-batch Welford variance merge pipeline.
// Each accepted beat carries one bin of batch A and batch B and yields one result
// beat from the ninth pipeline stage; a new bin can enter every cycle unless a rebuild
// runs or the full pipe is held, and bubbles in the pipe let input continue while the
// output beat is stalled. The 64x64 multiplies for the two means, the squared
// difference and the cross term are each split into 32x32 partial products in one
// stage and summed in the next. After any write to a listed register the reciprocals
// and the cross factor are rebuilt by a radix-2 divider and a shift-add multiplier;
// during the rebuild csr_ready and req_stall hold the block off.
module welford_variance_merge_top
   import wvm_pkg::*;
#(
   parameter int FRAC_BITS = FracBitsDefault
) (
   input  logic               clock,
   input  logic               reset,
   // configuration write channel
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [2:0]         csr_index,
   input  logic [WeightW-1:0] csr_wdata,
   // bin input channel
   input  logic               req_valid,
   output logic               req_stall,
   input  logic signed [63:0] req_sum_a,
   input  logic signed [63:0] req_sum_b,
   input  logic [62:0]        req_m2_a,
   input  logic [62:0]        req_m2_b,
   input  logic               req_last_bin,
   // result channel
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [63:0] rsp_sum_out,
   output logic [62:0]        rsp_m2_out,
   output logic [WeightW:0]   rsp_merged_weight,
   output logic [CountW:0]    rsp_merged_count,
   output logic               rsp_bad_bookkeeping,
   output logic               rsp_overflow,
   output logic               rsp_last_out
);

   localparam logic [62:0] Max63 = {63{1'b1}};

   // configuration and derived state
   logic [WeightW-1:0] weight_a_ff, weight_b_ff;
   logic [CountW-1:0]  count_a_ff, count_b_ff;
   logic               variance_on_ff;
   logic [63:0]        recip_a_ff, recip_b_ff, cross_ff;

   dv_state_type state_ff, state_in;
   logic         busy, div_step, div_last, mult_last;
   logic         csr_write, csr_listed;

   // divider and multiplier datapath
   logic [127:0]     num_ff;
   logic [WeightW:0] rem_ff, dvs_ff;
   logic [63:0]      quo_ff;
   logic [6:0]       cnt_ff;
   logic [79:0]      prod_ff, mcand_ff;
   logic [WeightW-1:0] mplier_ff;
   logic [WeightW+1:0] rem_sh;
   logic             qbit;
   logic [WeightW:0] rem_nx;
   logic [63:0]      quo_nx;

   assign csr_write  = csr_valid && csr_ready;
   assign csr_listed = (csr_index == CSR_WEIGHT_A) || (csr_index == CSR_WEIGHT_B) ||
                       (csr_index == CSR_COUNT_A) || (csr_index == CSR_COUNT_B) ||
                       (csr_index == CSR_VARIANCE_ON);

   // register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         weight_a_ff    <= '0;
         weight_b_ff    <= '0;
         count_a_ff     <= '0;
         count_b_ff     <= '0;
         variance_on_ff <= 1'b0;
      end else if (csr_write) begin
         case (csr_index)
            CSR_WEIGHT_A:    weight_a_ff    <= csr_wdata;
            CSR_WEIGHT_B:    weight_b_ff    <= csr_wdata;
            CSR_COUNT_A:     count_a_ff     <= csr_wdata[CountW-1:0];
            CSR_COUNT_B:     count_b_ff     <= csr_wdata[CountW-1:0];
            CSR_VARIANCE_ON: variance_on_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // sequencer next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         DV_IDLE:   if (csr_write && csr_listed) state_in = DV_LOAD_A;
         DV_LOAD_A: state_in = DV_DIV_A;
         DV_DIV_A:  if (div_last) state_in = DV_LOAD_B;
         DV_LOAD_B: state_in = DV_DIV_B;
         DV_DIV_B:  if (div_last) state_in = DV_MULT;
         DV_MULT:   if (mult_last) state_in = DV_LOAD_C;
         DV_LOAD_C: state_in = DV_DIV_C;
         DV_DIV_C:  if (div_last) state_in = DV_IDLE;
         default:   state_in = DV_IDLE;
      endcase
   end

   // sequencer outputs
   always_comb begin
      busy     = 1'b1;
      div_step = 1'b0;
      case (state_ff)
         DV_IDLE:  busy = 1'b0;
         DV_DIV_A: div_step = 1'b1;
         DV_DIV_B: div_step = 1'b1;
         DV_DIV_C: div_step = 1'b1;
         default:  div_step = 1'b0;
      endcase
   end

   assign div_last  = (cnt_ff == 7'd127);
   assign mult_last = (cnt_ff == 7'(WeightW - 1));
   assign csr_ready = !busy;

   always_ff @(posedge clock) begin
      if (reset) state_ff <= DV_IDLE;
      else       state_ff <= state_in;
   end

   // one restoring division step
   always_comb begin
      rem_sh = {rem_ff, num_ff[127]};
      qbit   = (rem_sh >= {1'b0, dvs_ff});
      rem_nx = qbit ? (WeightW+1)'(rem_sh - {1'b0, dvs_ff}) : rem_sh[WeightW:0];
      quo_nx = {quo_ff[62:0], qbit};
   end

   // counter and division/multiply registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else if (div_step || state_ff == DV_MULT) begin
         cnt_ff <= (div_last && div_step) || (mult_last && state_ff == DV_MULT) ?
                   7'd0 : cnt_ff + 7'd1;
      end else begin
         cnt_ff <= '0;
      end
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         DV_LOAD_A, DV_LOAD_B: begin
            num_ff <= 128'd1 << 63;
            rem_ff <= '0;
            quo_ff <= '0;
            dvs_ff <= {1'b0, (state_ff == DV_LOAD_A) ? weight_a_ff : weight_b_ff};
            prod_ff   <= '0;
            mcand_ff  <= 80'(weight_a_ff);
            mplier_ff <= weight_b_ff;
         end
         DV_LOAD_C: begin
            num_ff <= {24'b0, prod_ff, 24'b0};
            rem_ff <= '0;
            quo_ff <= '0;
            dvs_ff <= {1'b0, weight_a_ff} + {1'b0, weight_b_ff};
         end
         DV_MULT: begin
            if (mplier_ff[0]) prod_ff <= prod_ff + mcand_ff;
            mcand_ff  <= mcand_ff << 1;
            mplier_ff <= mplier_ff >> 1;
         end
         DV_DIV_A, DV_DIV_B, DV_DIV_C: begin
            num_ff <= num_ff << 1;
            rem_ff <= rem_nx;
            quo_ff <= quo_nx;
         end
         default: ;
      endcase
   end

   // derived constants land at the end of each division
   always_ff @(posedge clock) begin
      if (reset) begin
         recip_a_ff <= '0;
         recip_b_ff <= '0;
         cross_ff   <= '0;
      end else if (div_step && div_last) begin
         case (state_ff)
            DV_DIV_A: recip_a_ff <= (weight_a_ff == '0) ? 64'd0 : quo_nx;
            DV_DIV_B: recip_b_ff <= (weight_b_ff == '0) ? 64'd0 : quo_nx;
            DV_DIV_C: cross_ff   <= (weight_a_ff == '0 || weight_b_ff == '0) ?
                                    64'd0 : quo_nx;
            default: ;
         endcase
      end
   end

   // pipeline flow control: stage k loads when empty or its successor loads
   logic [9:1] valid_ff;
   logic [9:1] ld;
   logic       req_take;

   always_comb begin
      ld[9] = !valid_ff[9] || !rsp_stall;
      for (int k = 8; k >= 1; k--) ld[k] = !valid_ff[k] || ld[k+1];
   end

   assign req_stall = !ld[1] || busy;
   assign req_take  = req_valid && !req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         if (ld[1]) valid_ff[1] <= req_take;
         for (int k = 2; k <= 9; k++) if (ld[k]) valid_ff[k] <= valid_ff[k-1];
      end
   end

   // stage 1 inputs: magnitudes and the saturated sum
   logic [63:0] sa_u, sb_u, sum_raw;
   side_type    side_in;
   side_type    side_ff [1:8];

   always_comb begin
      sa_u    = req_sum_a;
      sb_u    = req_sum_b;
      sum_raw = sa_u + sb_u;
      side_in.sum_a   = sa_u;
      side_in.sum_ovf = (sa_u[63] == sb_u[63]) && (sum_raw[63] != sa_u[63]);
      side_in.sum_sat = side_in.sum_ovf ? (sa_u[63] ? {1'b1, 63'b0} : {1'b0, Max63})
                                        : sum_raw;
      side_in.m2_a    = req_m2_a;
      side_in.m2_b    = req_m2_b;
      side_in.last    = req_last_bin;
   end

   always_ff @(posedge clock) begin
      if (ld[1]) side_ff[1] <= side_in;
      for (int k = 2; k <= 8; k++) if (ld[k]) side_ff[k] <= side_ff[k-1];
   end

   logic [63:0] mag_a1, mag_b1;
   logic        na1, nb1, na2, nb2, na3, nb3;
   pp_type      pa2, pb2, pd5, pc7;
   logic [63:0] ma3, mb3, d4, sq6;
   logic        ov6, ov7, tov8;
   logic [62:0] term8;
   logic [127:0] pa_full, pb_full, pd_full, pc_full;

   always_ff @(posedge clock) begin
      if (ld[1]) begin
         mag_a1 <= sa_u[63] ? 64'd0 - sa_u : sa_u;
         mag_b1 <= sb_u[63] ? 64'd0 - sb_u : sb_u;
         na1    <= sa_u[63];
         nb1    <= sb_u[63];
      end
   end

   // stage 2: partial products of the two means
   always_ff @(posedge clock) begin
      if (ld[2]) begin
         pa2 <= pp_mul(mag_a1, recip_a_ff);
         pb2 <= pp_mul(mag_b1, recip_b_ff);
         na2 <= na1;
         nb2 <= nb1;
      end
   end

   // stage 3: means in the sum's fixed point
   assign pa_full = pp_sum(pa2);
   assign pb_full = pp_sum(pb2);

   always_ff @(posedge clock) begin
      if (ld[3]) begin
         ma3 <= pa_full[126:63];
         mb3 <= pb_full[126:63];
         na3 <= na2;
         nb3 <= nb2;
      end
   end

   // stage 4: distance between the means
   always_ff @(posedge clock) begin
      if (ld[4]) begin
         if (na3 != nb3) d4 <= ma3 + mb3;
         else            d4 <= (ma3 > mb3) ? ma3 - mb3 : mb3 - ma3;
      end
   end

   // stage 5: partial products of the square
   always_ff @(posedge clock) begin
      if (ld[5]) pd5 <= pp_mul(d4, d4);
   end

   // stage 6: square rescaled, flag if it does not fit
   assign pd_full = pp_sum(pd5);

   always_ff @(posedge clock) begin
      if (ld[6]) begin
         sq6 <= pd_full[FRAC_BITS+63:FRAC_BITS];
         ov6 <= (pd_full >> (FRAC_BITS + 64)) != '0;
      end
   end

   // stage 7: partial products of square times cross factor
   always_ff @(posedge clock) begin
      if (ld[7]) begin
         pc7 <= pp_mul(sq6, cross_ff);
         ov7 <= ov6;
      end
   end

   // stage 8: cross term, saturated
   assign pc_full = pp_sum(pc7);

   always_ff @(posedge clock) begin
      if (ld[8]) begin
         tov8  <= ov7 || (pc_full[127:64+CrossFrac-1] != '0);
         term8 <= (ov7 || (pc_full[127:64+CrossFrac-1] != '0)) ?
                  Max63 : pc_full[CrossFrac+62:CrossFrac];
      end
   end

   // stage 9 logic: M2 sums, special cases, output beat
   logic        bad, m2_ovf1, m2_ovf2;
   logic [63:0] m2_ab, m2_abt;
   logic [62:0] m2_sel, m2_ab63;
   logic        ovf_sel;

   always_comb begin
      bad = variance_on_ff &&
            (((weight_a_ff == '0) != (count_a_ff == '0)) ||
             ((weight_b_ff == '0) != (count_b_ff == '0)));
      m2_ab   = {1'b0, side_ff[8].m2_a} + {1'b0, side_ff[8].m2_b};
      m2_ovf1 = m2_ab[63];
      m2_ab63 = m2_ovf1 ? Max63 : m2_ab[62:0];
      m2_abt  = {1'b0, m2_ab63} + {1'b0, term8};
      m2_ovf2 = m2_abt[63];
      if (!variance_on_ff || weight_b_ff == '0) begin
         m2_sel  = side_ff[8].m2_a;
         ovf_sel = side_ff[8].sum_ovf;
      end else if (weight_a_ff == '0) begin
         m2_sel  = side_ff[8].m2_b;
         ovf_sel = side_ff[8].sum_ovf;
      end else begin
         m2_sel  = m2_ovf2 ? Max63 : m2_abt[62:0];
         ovf_sel = side_ff[8].sum_ovf || tov8 || m2_ovf1 || m2_ovf2;
      end
   end

   always_ff @(posedge clock) begin
      if (ld[9]) begin
         rsp_last_out <= side_ff[8].last;
         if (bad) begin
            rsp_sum_out         <= side_ff[8].sum_a;
            rsp_m2_out          <= side_ff[8].m2_a;
            rsp_merged_weight   <= {1'b0, weight_a_ff};
            rsp_merged_count    <= {1'b0, count_a_ff};
            rsp_bad_bookkeeping <= 1'b1;
            rsp_overflow        <= 1'b0;
         end else begin
            rsp_sum_out         <= side_ff[8].sum_sat;
            rsp_m2_out          <= m2_sel;
            rsp_merged_weight   <= {1'b0, weight_a_ff} + {1'b0, weight_b_ff};
            rsp_merged_count    <= {1'b0, count_a_ff} + {1'b0, count_b_ff};
            rsp_bad_bookkeeping <= 1'b0;
            rsp_overflow        <= ovf_sel;
         end
      end
   end

   assign rsp_valid = valid_ff[9];

   // no bin enters while constants are being rebuilt
   a_no_take_busy: assert property (@(posedge clock) disable iff (reset)
      req_take |-> state_ff == DV_IDLE)
      else $error("bin accepted during derivation");

   // a listed register write always starts a rebuild
   a_write_derives: assert property (@(posedge clock) disable iff (reset)
      csr_write && csr_listed |=> state_ff == DV_LOAD_A)
      else $error("register write did not start derivation");

   // bookkeeping passthrough never reports overflow
   a_bad_no_ovf: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_bad_bookkeeping |-> !rsp_overflow)
      else $error("overflow flagged on bookkeeping passthrough");

   // a held output beat keeps its payload
   a_out_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_sum_out) && $stable(rsp_m2_out))
      else $error("stalled result changed");

endmodule

// ===== bench/welford_variance_merge_top_test.sv =====
// Testbench for the two-batch Welford variance merge block: self-checking, random bursts.
module welford_variance_merge_top_test;
   import wvm_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int FracBits = FracBitsDefault;
   localparam logic [63:0] Max63 = 64'h7FFF_FFFF_FFFF_FFFF;
   localparam logic [39:0] MaxWeight = 40'hFF_FFFF_FFFF;
   localparam logic [31:0] MaxCount = 32'hFFFF_FFFF;

   // expected merged bin
   typedef struct {
      logic signed [63:0] sum;
      logic [62:0]        m2;
      logic [WeightW:0]   weight;
      logic [CountW:0]    count;
      bit                 bad;
      bit                 ovf;
      bit                 last;
   } merged_bin_type;

   // tracks register state and the queue of merged bins still owed by the block
   class merge_scoreboard;
      merged_bin_type owed_q[$];
      int          errors = 0;
      logic [39:0] wa = 0, wb = 0;
      logic [31:0] ca = 0, cb = 0;
      bit          var_on = 0;
      logic [63:0] inv_wa = 0, inv_wb = 0, cross_fac = 0;

      function void write_reg(csr_index_type idx, logic [39:0] v);
         logic [127:0] p;
         case (idx)
            CSR_WEIGHT_A: wa = v;
            CSR_WEIGHT_B: wb = v;
            CSR_COUNT_A: ca = v[31:0];
            CSR_COUNT_B: cb = v[31:0];
            CSR_VARIANCE_ON: var_on = v[0];
            default: return;
         endcase
         inv_wa = (wa != 0) ? 64'h8000_0000_0000_0000 / 64'(wa) : 64'd0;
         inv_wb = (wb != 0) ? 64'h8000_0000_0000_0000 / 64'(wb) : 64'd0;
         if (wa == 0 || wb == 0) begin
            cross_fac = 0;
         end else begin
            p = (128'(wa) * 128'(wb)) << CrossFrac;
            cross_fac = 64'(p / (128'(wa) + 128'(wb)));
         end
      endfunction

      // magnitude of sum/weight, sign returned separately
      function logic [63:0] mean_of(logic [63:0] s, logic [63:0] inv, output bit neg);
         logic [63:0]  mag;
         logic [127:0] p;
         neg = s[63];
         mag = neg ? -s : s;
         p = 128'(mag) * 128'(inv);
         return p[126:63];
      endfunction

      function logic [63:0] add63(logic [63:0] a, logic [63:0] b, inout bit ovf);
         logic [63:0] s;
         s = a + b;
         if (s > Max63) begin
            ovf = 1;
            return Max63;
         end
         return s;
      endfunction

      function void note_bin(logic [63:0] sa, logic [63:0] sb, logic [62:0] m2a,
                             logic [62:0] m2b, bit last);
         merged_bin_type e;
         bit           na, nb;
         logic [63:0]  ma, mb, d, sq, term, s, m2s;
         logic [127:0] p;
         e.last = last;
         e.bad = var_on && (((wa == 0) != (ca == 0)) || ((wb == 0) != (cb == 0)));
         if (e.bad) begin
            e.sum = sa;
            e.m2 = m2a;
            e.weight = 41'(wa);
            e.count = 33'(ca);
            e.ovf = 0;
            owed_q.push_back(e);
            return;
         end
         e.ovf = 0;
         s = sa + sb;
         if (sa[63] == sb[63] && s[63] != sa[63]) begin
            e.ovf = 1;
            s = sa[63] ? 64'h8000_0000_0000_0000 : Max63;
         end
         e.sum = s;
         if (!var_on || wb == 0) begin
            e.m2 = m2a;
         end else if (wa == 0) begin
            e.m2 = m2b;
         end else begin
            ma = mean_of(sa, inv_wa, na);
            mb = mean_of(sb, inv_wb, nb);
            if (na != nb) d = ma + mb;
            else d = (ma > mb) ? ma - mb : mb - ma;
            p = 128'(d) * 128'(d);
            if ((p >> (64 + FracBits)) != 0) begin
               e.ovf = 1;
               term = Max63;
            end else begin
               sq = 64'(p >> FracBits);
               p = 128'(sq) * 128'(cross_fac);
               if ((p >> (64 + CrossFrac - 1)) != 0) begin
                  e.ovf = 1;
                  term = Max63;
               end else begin
                  term = 64'(p >> CrossFrac);
               end
            end
            m2s = add63(64'(m2a), 64'(m2b), e.ovf);
            m2s = add63(m2s, term, e.ovf);
            e.m2 = 63'(m2s);
         end
         e.weight = 41'(wa) + 41'(wb);
         e.count = 33'(ca) + 33'(cb);
         owed_q.push_back(e);
      endfunction

      function void check_bin(merged_bin_type got);
         merged_bin_type e;
         if (owed_q.size() == 0) begin
            $error("result beat with nothing outstanding");
            errors++;
            return;
         end
         e = owed_q.pop_front();
         if (got.sum !== e.sum) begin
            $error("sum_out exp %h got %h", e.sum, got.sum); errors++;
         end
         if (got.m2 !== e.m2) begin
            $error("m2_out exp %h got %h", e.m2, got.m2); errors++;
         end
         if (got.weight !== e.weight) begin
            $error("merged_weight exp %h got %h", e.weight, got.weight); errors++;
         end
         if (got.count !== e.count) begin
            $error("merged_count exp %h got %h", e.count, got.count); errors++;
         end
         if (got.bad !== e.bad) begin
            $error("bad_bookkeeping exp %b got %b", e.bad, got.bad); errors++;
         end
         if (got.ovf !== e.ovf) begin
            $error("overflow exp %b got %b", e.ovf, got.ovf); errors++;
         end
         if (got.last !== e.last) begin
            $error("last_out exp %b got %b", e.last, got.last); errors++;
         end
      endfunction
   endclass

   logic               clock = 0, reset = 1;
   logic               csr_valid = 0, csr_ready;
   logic [2:0]         csr_index = '0;
   logic [39:0]        csr_wdata = '0;
   logic               req_valid = 0, req_stall;
   logic signed [63:0] req_sum_a = '0, req_sum_b = '0;
   logic [62:0]        req_m2_a = '0, req_m2_b = '0;
   logic               req_last_bin = 0;
   logic               rsp_valid, rsp_stall = 0;
   logic signed [63:0] rsp_sum_out;
   logic [62:0]        rsp_m2_out;
   logic [WeightW:0]   rsp_merged_weight;
   logic [CountW:0]    rsp_merged_count;
   logic               rsp_bad_bookkeeping, rsp_overflow, rsp_last_out;

   merge_scoreboard sb = new();
   bit noisy = 1;

   welford_variance_merge_top #(.FRAC_BITS(FracBits)) DUT (.*);

   initial begin
      forever #2 clock = ~clock;
   end

   initial begin
      #2ms;
      $display("welford_variance_merge_top: mismatch");
      $finish;
   end

   // result side: random stall bursts, check every accepted beat
   initial begin
      forever begin
         @(negedge clock);
         if (noisy && $urandom_range(0, 3) == 0) begin
            rsp_stall = 1;
            repeat ($urandom_range(1, 11) - 1) @(negedge clock);
         end else begin
            rsp_stall = 0;
            repeat ($urandom_range(0, 7)) @(negedge clock);
         end
      end
   end

   always @(posedge clock) begin
      merged_bin_type got;
      if (!reset && rsp_valid && !rsp_stall) begin
         got.sum = rsp_sum_out;
         got.m2 = rsp_m2_out;
         got.weight = rsp_merged_weight;
         got.count = rsp_merged_count;
         got.bad = rsp_bad_bookkeeping;
         got.ovf = rsp_overflow;
         got.last = rsp_last_out;
         sb.check_bin(got);
      end
   end

   // wait until every owed result has come back
   task automatic wait_drained();
      while (sb.owed_q.size() != 0) @(posedge clock);
      repeat (12) @(posedge clock);
   endtask

   task automatic write_csr(logic [2:0] idx, logic [39:0] v);
      @(negedge clock);
      csr_valid = 1;
      csr_index = idx;
      csr_wdata = v;
      forever begin
         @(posedge clock);
         if (csr_ready) break;
      end
      sb.write_reg(csr_index_type'(idx), v);
      @(negedge clock);
      csr_valid = 0;
   endtask

   task automatic set_regs(logic [39:0] wa, logic [39:0] wb, logic [31:0] ca,
                           logic [31:0] cb, bit on);
      wait_drained();
      write_csr(CSR_WEIGHT_A, wa);
      write_csr(CSR_WEIGHT_B, wb);
      write_csr(CSR_COUNT_A, 40'(ca) | (40'($urandom_range(0, 255)) << 32));
      write_csr(CSR_COUNT_B, 40'(cb));
      write_csr(CSR_VARIANCE_ON, 40'(on));
      // unlisted index: must be ignored
      if ($urandom_range(0, 2) == 0)
         write_csr(3'($urandom_range(CSR_VARIANCE_ON + 1, 7)), 40'({$urandom, $urandom}));
   endtask

   // one bin beat, held until accepted
   task automatic send_bin(logic [63:0] sa, logic [63:0] sb_v, logic [62:0] m2a,
                           logic [62:0] m2b, bit last);
      @(negedge clock);
      if (noisy && $urandom_range(0, 3) == 0) begin
         req_valid = 0;
         repeat ($urandom_range(1, 11)) @(negedge clock);
      end
      req_valid = 1;
      req_sum_a = sa;
      req_sum_b = sb_v;
      req_m2_a = m2a;
      req_m2_b = m2b;
      req_last_bin = last;
      forever begin
         @(posedge clock);
         if (!req_stall) break;
      end
      sb.note_bin(sa, sb_v, m2a, m2b, last);
   endtask

   task automatic end_burst();
      @(negedge clock);
      req_valid = 0;
   endtask

   function automatic logic [63:0] pick_sum();
      case ($urandom_range(0, 7))
         0: return 64'h7FFF_FFFF_FFFF_FFFF;
         1: return 64'h8000_0000_0000_0000;
         2: return 64'(0);
         3, 4: return 64'(signed'({$urandom, $urandom}) >>> $urandom_range(8, 40));
         default: return {$urandom, $urandom};
      endcase
   endfunction

   function automatic logic [62:0] pick_m2();
      case ($urandom_range(0, 5))
         0: return '1;
         1: return '0;
         2, 3: return 63'({$urandom, $urandom} >> $urandom_range(4, 40));
         default: return 63'({$urandom, $urandom});
      endcase
   endfunction

   function automatic logic [39:0] pick_weight();
      case ($urandom_range(0, 6))
         0: return 0;
         1: return 1;
         2: return MaxWeight;
         3, 4: return 40'($urandom_range(1, 1000));
         default: return 40'({$urandom, $urandom});
      endcase
   endfunction

   task automatic directed_trio(int k);
      send_bin(64'h7FFF_FFFF_FFFF_FFFF, 64'h7FFF_FFFF_FFFF_FFFF, '1, '1, k[0]);
      send_bin(64'h8000_0000_0000_0000, 64'h8000_0000_0000_0000, '0, '1, 1'b1);
      send_bin(64'(-(k * 1000) <<< 32), 64'((k + 3) <<< 32), 63'(k), '0, 1'b0);
      end_burst();
   endtask

   initial begin
      logic [39:0] wa, wb;
      logic [31:0] ca, cb;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 0;

      // directed: reset state, then the named special cases and extremes
      directed_trio(0);
      set_regs(3, 5, 1, 2, 1);
      directed_trio(1);
      set_regs(0, 5, 1, 2, 1);            // weight/count disagree on A
      directed_trio(2);
      set_regs(4, 7, 1, 0, 1);            // disagree on B
      directed_trio(3);
      set_regs(0, 9, 0, 3, 1);            // empty A
      directed_trio(4);
      set_regs(9, 0, 3, 0, 1);            // empty B
      directed_trio(5);
      set_regs(MaxWeight, MaxWeight, MaxCount, MaxCount, 1);
      directed_trio(6);
      set_regs(1, 1, 1, 1, 0);            // variance off
      directed_trio(7);

      // random phases
      for (int ph = 0; ph < 16; ph++) begin
         wa = pick_weight();
         wb = pick_weight();
         ca = (wa == 0) ? 32'd0 : 32'($urandom_range(1, 50));
         cb = (wb == 0) ? 32'd0 : 32'($urandom_range(1, 50));
         if ($urandom_range(0, 4) == 0) ca = (ca == 0) ? MaxCount : 32'd0;
         if ($urandom_range(0, 9) == 0) cb = $urandom;
         if (ph >= 13) noisy = 0;
         set_regs(wa, wb, ca, cb, $urandom_range(0, 5) != 0);
         for (int i = 0; i < 52; i++)
            send_bin(pick_sum(), pick_sum(), pick_m2(), pick_m2(), i == 51);
         end_burst();
      end

      wait_drained();
      if (sb.errors == 0)
         $display("welford_variance_merge_top: match");
      else
         $display("welford_variance_merge_top: mismatch");
      $finish;
   end

endmodule
